// ===== src/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types, result codes and character lookups for the quoted string
// unescaper.
// ----------------------------------------------------------------------------
package qsu_pkg;

   localparam logic [1:0] ST_BYTE   = 2'd0;
   localparam logic [1:0] ST_OK     = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;
   localparam logic [1:0] ST_UNTERM = 2'd3;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic       two;
      logic [7:0] byte0;
      logic [1:0] st0;
      logic [7:0] byte1;
      logic [1:0] st1;
   } qsu_entry_type;

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // {valid, value} for the single-character escapes
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h27:   r = {1'b1, 8'h27};
         8'h22:   r = {1'b1, 8'h22};
         8'h5c:   r = {1'b1, 8'h5c};
         8'h61:   r = {1'b1, 8'h07};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0c};
         8'h6e:   r = {1'b1, 8'h0a};
         8'h72:   r = {1'b1, 8'h0d};
         8'h74:   r = {1'b1, 8'h09};
         8'h76:   r = {1'b1, 8'h0b};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/quoted_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescaper
// Streaming decoder for a quoted token with C-style backslash escapes.
// ----------------------------------------------------------------------------
// One character is taken per cycle while req_full is low. Each character
// yields zero, one or two results; the decoder writes any results as one entry
// into a four-entry queue, and the output stage hands out one result per
// cycle while rsp_pop is held, so a character that yields two results
// occupies the output for two pops. Sustained rate is one character per
// cycle, falling when paired results or a stalled consumer back the queue
// up. The first result of a character passes through a queue slot and the
// output register before it shows on the rsp_ ports, and can then be popped.
module quoted_string_unescaper
   import qsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_in,
   input  logic       req_token_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_byte_out,
   output logic [1:0] rsp_status,
   output logic       rsp_run_last
);

   logic          accept;
   logic          ent_valid;
   qsu_entry_type ent;
   qsu_entry_type head;
   logic          head_valid;
   logic          head_take;
   logic          q_full;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   qsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_in   (req_char_in),
      .token_end (req_token_end),
      .ent_valid (ent_valid),
      .ent       (ent)
   );

   qsu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && ent_valid),
      .push_data (ent),
      .pop       (head_take),
      .head      (head),
      .nonempty  (head_valid),
      .full      (q_full)
   );

   qsu_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .head_take    (head_take),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_byte_out (rsp_byte_out),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

endmodule

// ===== src/qsu_front.sv =====
// ----------------------------------------------------------------------------
// qsu_front
// Escape decoder: tracks the token phase and turns each accepted character
// into a queue entry of zero, one or two results.
// ----------------------------------------------------------------------------
module qsu_front
   import qsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    char_in,
   input  logic          token_end,
   output logic          ent_valid,
   output qsu_entry_type ent
);

   localparam logic [2:0] PH_OPEN = 3'd0;
   localparam logic [2:0] PH_BODY = 3'd1;
   localparam logic [2:0] PH_ESC  = 3'd2;
   localparam logic [2:0] PH_HEX  = 3'd3;
   localparam logic [2:0] PH_OCT  = 3'd4;
   localparam logic [2:0] PH_SKIP = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic [1:0] count_ff, count_in;
   logic [8:0] accum_ff, accum_in;

   logic       is_quote;
   logic       is_oct;
   logic [4:0] hx;
   logic [8:0] sx;

   assign is_quote = (char_in == 8'h22) || (char_in == 8'h27);
   assign is_oct   = (char_in >= 8'h30) && (char_in <= 8'h37);
   assign hx       = hex_digit(char_in);
   assign sx       = simple_escape(char_in);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      accum_in  = accum_ff;
      ent_valid = 1'b0;
      ent       = '0;
      if (phase_ff == PH_SKIP) begin
         if (token_end) begin
            phase_in = PH_OPEN;
            count_in = 2'd0;
            accum_in = 9'd0;
         end
      end else if (phase_ff < PH_BODY || phase_ff > PH_OCT) begin
         count_in = 2'd0;
         accum_in = 9'd0;
         if (!is_quote) begin
            ent_valid = 1'b1;
            ent.st0   = ST_BAD;
            phase_in  = token_end ? PH_OPEN : PH_SKIP;
         end else if (token_end) begin
            ent_valid = 1'b1;
            ent.st0   = ST_UNTERM;
            phase_in  = PH_OPEN;
         end else begin
            phase_in = PH_BODY;
         end
      end else if (token_end) begin
         ent_valid = 1'b1;
         phase_in  = PH_OPEN;
         count_in  = 2'd0;
         accum_in  = 9'd0;
         if (!is_quote) begin
            ent.st0 = ST_UNTERM;
         end else if (phase_ff == PH_ESC || (phase_ff == PH_HEX && count_ff == 2'd0)) begin
            ent.st0 = ST_BAD;
         end else if (phase_ff == PH_HEX || phase_ff == PH_OCT) begin
            ent.two   = 1'b1;
            ent.byte0 = accum_ff[7:0];
            ent.st0   = ST_BYTE;
            ent.st1   = ST_OK;
         end else begin
            ent.st0 = ST_OK;
         end
      end else begin
         case (phase_ff)
            PH_BODY: begin
               if (char_in == 8'h5c) begin
                  phase_in = PH_ESC;
               end else begin
                  ent_valid = 1'b1;
                  ent.byte0 = char_in;
               end
            end
            PH_ESC: begin
               if (sx[8]) begin
                  ent_valid = 1'b1;
                  ent.byte0 = sx[7:0];
                  phase_in  = PH_BODY;
               end else if (char_in == 8'h78) begin
                  phase_in = PH_HEX;
                  count_in = 2'd0;
                  accum_in = 9'd0;
               end else if (is_oct) begin
                  phase_in = PH_OCT;
                  count_in = 2'd1;
                  accum_in = {6'd0, char_in[2:0]};
               end else begin
                  ent_valid = 1'b1;
                  ent.st0   = ST_BAD;
                  phase_in  = PH_SKIP;
               end
            end
            PH_HEX, PH_OCT: begin
               if (phase_ff == PH_HEX && count_ff == 2'd0) begin
                  if (!hx[4]) begin
                     ent_valid = 1'b1;
                     ent.st0   = ST_BAD;
                     phase_in  = PH_SKIP;
                  end else begin
                     accum_in = {5'd0, hx[3:0]};
                     count_in = 2'd1;
                  end
               end else if (phase_ff == PH_HEX && hx[4]) begin
                  ent_valid = 1'b1;
                  ent.byte0 = {accum_ff[3:0], hx[3:0]};
                  phase_in  = PH_BODY;
                  count_in  = 2'd0;
                  accum_in  = 9'd0;
               end else if (phase_ff == PH_OCT && is_oct) begin
                  if (count_ff == 2'd2) begin
                     ent_valid = 1'b1;
                     ent.byte0 = {accum_ff[4:0], char_in[2:0]};
                     phase_in  = PH_BODY;
                     count_in  = 2'd0;
                     accum_in  = 9'd0;
                  end else begin
                     accum_in = {accum_ff[5:0], char_in[2:0]};
                     count_in = count_ff + 2'd1;
                  end
               end else begin
                  // digit run ended by a non-digit
                  ent_valid = 1'b1;
                  ent.byte0 = accum_ff[7:0];
                  count_in  = 2'd0;
                  accum_in  = 9'd0;
                  if (char_in == 8'h5c) begin
                     phase_in = PH_ESC;
                  end else begin
                     ent.two   = 1'b1;
                     ent.byte1 = char_in;
                     ent.st1   = ST_BYTE;
                     phase_in  = PH_BODY;
                  end
               end
            end
            default: begin
               phase_in = PH_OPEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         count_ff <= 2'd0;
         accum_ff <= 9'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         accum_ff <= accum_in;
      end
   end

endmodule

// ===== src/qsu_fifo.sv =====
// ----------------------------------------------------------------------------
// qsu_fifo
// Short queue of result entries between the decoder and the output stage.
// ----------------------------------------------------------------------------
module qsu_fifo
   import qsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  qsu_entry_type push_data,
   input  logic          pop,
   output qsu_entry_type head,
   output logic          nonempty,
   output logic          full
);

   qsu_entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign head     = slot_ff[rd_ptr_ff];
   assign nonempty = (count_ff != '0);
   assign full     = (count_ff == QCNT_W'(QDEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/qsu_emit.sv =====
// ----------------------------------------------------------------------------
// qsu_emit
// Output stage: takes queue entries and presents their results one
// transaction at a time.
// ----------------------------------------------------------------------------
module qsu_emit
   import qsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  qsu_entry_type head,
   input  logic          head_valid,
   output logic          head_take,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output logic [7:0]    rsp_byte_out,
   output logic [1:0]    rsp_status,
   output logic          rsp_run_last
);

   logic          valid_ff;
   logic          second_ff;
   qsu_entry_type entry_ff;
   logic          pop_fire;
   logic          done;

   assign pop_fire  = rsp_pop && valid_ff;
   assign done      = pop_fire && (!entry_ff.two || second_ff);
   assign head_take = head_valid && (!valid_ff || done);

   assign rsp_empty    = !valid_ff;
   assign rsp_byte_out = second_ff ? entry_ff.byte1 : entry_ff.byte0;
   assign rsp_status   = second_ff ? entry_ff.st1 : entry_ff.st0;
   assign rsp_run_last = !entry_ff.two || second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (head_take) begin
         valid_ff  <= 1'b1;
         second_ff <= 1'b0;
      end else if (done) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (pop_fire) begin
         second_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) begin
         entry_ff <= head;
      end
   end

   a_second_in_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (valid_ff && entry_ff.two))
      else $error("second result shown for a single-result entry");

   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && entry_ff.two && !second_ff) |=> (valid_ff && second_ff))
      else $error("second result of a pair lost");

   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_status != ST_BYTE) |-> (rsp_byte_out == 8'd0))
      else $error("status result carries a non-zero byte");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_status != ST_BYTE) |-> rsp_run_last)
      else $error("status result not marked last");

endmodule
